// ===== sv/gpfp_pkg.sv =====
// constants and types shared by the gamepad poll frame parser
// no dependencies; used by gamepad_poll_frame_parser
package gpfp_pkg;

  localparam int unsigned BASE_FRAME_BYTES     = 9;
  localparam int unsigned EXTRA_PRESSURE_BYTES = 12;
  localparam int unsigned STORE_BYTES          = 21;
  localparam int unsigned LONG_FRAME_BYTES     = BASE_FRAME_BYTES + EXTRA_PRESSURE_BYTES;
  localparam int unsigned POS_W                = $clog2(LONG_FRAME_BYTES + 1);

  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      word_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [1:0]       status_t;

  localparam byte_t MODE_DIGITAL  = 8'h41;
  localparam byte_t MODE_ANALOG   = 8'h73;
  localparam byte_t MODE_PRESSURE = 8'h79;
  localparam byte_t MODE_CFG_MASK = 8'hF0;

  localparam status_t STATUS_OK  = 2'd0;
  localparam status_t STATUS_CFG = 2'd1;
  localparam status_t STATUS_BAD = 2'd2;

  localparam pos_t ANALOG_INDEX_RESET = pos_t'(5);
  localparam pos_t MODE_POS           = pos_t'(1);
  localparam pos_t BTN_LO_POS         = pos_t'(3);
  localparam pos_t BTN_HI_POS         = pos_t'(4);
  localparam pos_t STICK_HI_POS       = pos_t'(7);
  localparam pos_t STICK_LO_POS       = pos_t'(8);

endpackage

// ===== sv/gamepad_poll_frame_parser.sv =====
// gamepad poll frame parser: collects frame bytes, decodes the mode byte and
// reports buttons, stick and one analog byte per finished frame
// depends on gpfp_pkg
//
//   channel  direction  handshake            payload
//   in_      request    in_valid / in_stall  in_rx_byte, in_frame_start
//   out_     result     out_valid/out_stall  status, mode, buttons, stick, masks, analog
//   cfg_     write      cfg_valid/cfg_ready  cfg_analog_index
//
// one byte is accepted every cycle while in_stall is low; the frame state and
// byte store update at the accepting edge, as does the output register when
// that byte ends a frame; in_stall is high only while a result is held and
// out_stall is high; synchronous active-low reset clears the byte store,
// latched words and the analog index (to 5); cfg_ready is always high
module gamepad_poll_frame_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_frame_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_frame_status,
  output logic [7:0]           out_mode_id,
  output logic [15:0]          out_button_bits,
  output logic [15:0]          out_left_stick,
  output logic                 out_buttons_changed,
  output logic                 out_stick_changed,
  output logic [15:0]          out_pressed_mask,
  output logic [15:0]          out_released_mask,
  output logic [7:0]           out_analog_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           cfg_analog_index
);

  gpfp_pkg::pos_t    analog_index_r;
  gpfp_pkg::pos_t    pos_r, pos_nxt;
  logic              open_r, open_nxt;
  gpfp_pkg::byte_t   store_r [gpfp_pkg::STORE_BYTES];
  gpfp_pkg::byte_t   store_wr [gpfp_pkg::STORE_BYTES];
  gpfp_pkg::byte_t   store_nxt [gpfp_pkg::STORE_BYTES];
  gpfp_pkg::word_t   cur_btn_r, cur_btn_nxt, prev_btn_r, prev_btn_nxt;
  gpfp_pkg::word_t   cur_stick_r, cur_stick_nxt, prev_stick_r, prev_stick_nxt;

  logic              out_valid_r;
  gpfp_pkg::status_t out_status_r, status_nxt;
  gpfp_pkg::byte_t   out_mode_r;
  gpfp_pkg::word_t   out_btn_r, out_stick_r, out_pressed_r, out_released_r;
  logic              out_bchg_r, out_schg_r;
  gpfp_pkg::byte_t   out_analog_r, analog_nxt;

  logic              accept, wr_en, done, mode_ok, bchg, schg;
  gpfp_pkg::pos_t    pos_cur, pos_inc, frame_len;
  gpfp_pkg::byte_t   mode;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    pos_cur = in_frame_start ? '0 : pos_r;
    wr_en   = accept && (in_frame_start || open_r);
    pos_inc = pos_cur + gpfp_pkg::pos_t'(1);
    for (int i = 0; i < gpfp_pkg::STORE_BYTES; i++) begin
      store_wr[i] = (wr_en && pos_cur == gpfp_pkg::pos_t'(i)) ? in_rx_byte : store_r[i];
    end
    mode      = store_wr[gpfp_pkg::MODE_POS];
    frame_len = (mode == gpfp_pkg::MODE_PRESSURE) ? gpfp_pkg::pos_t'(gpfp_pkg::LONG_FRAME_BYTES)
                                                  : gpfp_pkg::pos_t'(gpfp_pkg::BASE_FRAME_BYTES);
    done      = wr_en && (pos_inc >= frame_len);
  end

  always_comb begin
    unique case (mode) inside
      gpfp_pkg::MODE_DIGITAL, gpfp_pkg::MODE_ANALOG, gpfp_pkg::MODE_PRESSURE: begin
        mode_ok = 1'b1;
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_nxt        = pos_r;
    open_nxt       = open_r;
    store_nxt      = store_wr;
    cur_btn_nxt    = cur_btn_r;
    prev_btn_nxt   = prev_btn_r;
    cur_stick_nxt  = cur_stick_r;
    prev_stick_nxt = prev_stick_r;
    status_nxt     = gpfp_pkg::STATUS_OK;
    if (wr_en) begin
      pos_nxt  = pos_inc;
      open_nxt = 1'b1;
    end
    if (done) begin
      pos_nxt  = '0;
      open_nxt = 1'b0;
      if (mode_ok) begin
        prev_btn_nxt   = cur_btn_r;
        cur_btn_nxt    = {store_wr[gpfp_pkg::BTN_HI_POS], store_wr[gpfp_pkg::BTN_LO_POS]};
        prev_stick_nxt = cur_stick_r;
        cur_stick_nxt  = {store_wr[gpfp_pkg::STICK_HI_POS], store_wr[gpfp_pkg::STICK_LO_POS]};
      end else begin
        // config mode or bad header wipes the store
        for (int i = 0; i < gpfp_pkg::STORE_BYTES; i++) begin
          store_nxt[i] = '0;
        end
        status_nxt = ((mode & gpfp_pkg::MODE_CFG_MASK) == gpfp_pkg::MODE_CFG_MASK)
                   ? gpfp_pkg::STATUS_CFG : gpfp_pkg::STATUS_BAD;
      end
    end
    bchg = (cur_btn_nxt != prev_btn_nxt);
    schg = (cur_stick_nxt != prev_stick_nxt);
    // reads the store with this byte written in; config or bad modes read zero
    if (analog_index_r < gpfp_pkg::pos_t'(gpfp_pkg::STORE_BYTES) && mode_ok) begin
      analog_nxt = store_wr[analog_index_r];
    end else begin
      analog_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_index_r <= gpfp_pkg::ANALOG_INDEX_RESET;
      pos_r          <= '0;
      open_r         <= 1'b0;
      cur_btn_r      <= '0;
      prev_btn_r     <= '0;
      cur_stick_r    <= '0;
      prev_stick_r   <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < gpfp_pkg::STORE_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        analog_index_r <= cfg_analog_index;
      end
      pos_r        <= pos_nxt;
      open_r       <= open_nxt;
      store_r      <= store_nxt;
      cur_btn_r    <= cur_btn_nxt;
      prev_btn_r   <= prev_btn_nxt;
      cur_stick_r  <= cur_stick_nxt;
      prev_stick_r <= prev_stick_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r   <= status_nxt;
      out_mode_r     <= mode;
      out_btn_r      <= cur_btn_nxt;
      out_stick_r    <= cur_stick_nxt;
      out_bchg_r     <= bchg;
      out_schg_r     <= schg;
      out_pressed_r  <= bchg ? ~cur_btn_nxt : '0;
      out_released_r <= bchg ? ~prev_btn_nxt : '0;
      out_analog_r   <= analog_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_status    = out_status_r;
  assign out_mode_id         = out_mode_r;
  assign out_button_bits     = out_btn_r;
  assign out_left_stick      = out_stick_r;
  assign out_buttons_changed = out_bchg_r;
  assign out_stick_changed   = out_schg_r;
  assign out_pressed_mask    = out_pressed_r;
  assign out_released_mask   = out_released_r;
  assign out_analog_value    = out_analog_r;

`ifndef SYNTHESIS
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an accepted request");

  a_closed_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> pos_r == '0)
    else $error("byte position nonzero while no frame is open");

  a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < gpfp_pkg::pos_t'(gpfp_pkg::STORE_BYTES))
    else $error("byte position ran past the store");

  a_masks_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bchg_r |-> out_pressed_r == '0 && out_released_r == '0)
    else $error("masks set while buttons unchanged");
`endif

endmodule

// ===== tb/tb_gamepad_poll_frame_parser.sv =====
`timescale 1ns / 1ps
// testbench for gamepad_poll_frame_parser: directed and random poll frames, a
// byte-level predictor of the parser and a checker on the result channel
// depends on gpfp_pkg and gamepad_poll_frame_parser
module tb_gamepad_poll_frame_parser;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_BYTES    = 100;

  typedef struct packed {
    gpfp_pkg::status_t status;
    gpfp_pkg::byte_t   mode;
    gpfp_pkg::word_t   buttons;
    gpfp_pkg::word_t   stick;
    logic              buttons_changed;
    logic              stick_changed;
    gpfp_pkg::word_t   pressed;
    gpfp_pkg::word_t   released;
    gpfp_pkg::byte_t   analog;
  } frame_report_t;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  gpfp_pkg::byte_t   in_rx_byte       = '0;
  logic              in_frame_start   = 1'b0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  gpfp_pkg::status_t out_frame_status;
  gpfp_pkg::byte_t   out_mode_id;
  gpfp_pkg::word_t   out_button_bits;
  gpfp_pkg::word_t   out_left_stick;
  logic              out_buttons_changed;
  logic              out_stick_changed;
  gpfp_pkg::word_t   out_pressed_mask;
  gpfp_pkg::word_t   out_released_mask;
  gpfp_pkg::byte_t   out_analog_value;
  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [4:0]        cfg_analog_index = '0;

  // predictor state
  logic [4:0]      model_analog_index;
  logic [4:0]      model_pos;
  logic            model_open;
  gpfp_pkg::byte_t model_store [gpfp_pkg::STORE_BYTES];
  gpfp_pkg::word_t model_buttons;
  gpfp_pkg::word_t model_prev_buttons;
  gpfp_pkg::word_t model_stick;
  gpfp_pkg::word_t model_prev_stick;

  frame_report_t   expected_reports [$];
  gpfp_pkg::byte_t frame_buf [$];

  bit idle_on = 1'b1;
  int failures;
  int bytes_sent;
  int reports_checked;
  int index_settings;
  int status_seen [3];
  int idle_cycles;

  gamepad_poll_frame_parser DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .in_frame_start      (in_frame_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_status    (out_frame_status),
    .out_mode_id         (out_mode_id),
    .out_button_bits     (out_button_bits),
    .out_left_stick      (out_left_stick),
    .out_buttons_changed (out_buttons_changed),
    .out_stick_changed   (out_stick_changed),
    .out_pressed_mask    (out_pressed_mask),
    .out_released_mask   (out_released_mask),
    .out_analog_value    (out_analog_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_analog_index    (cfg_analog_index)
  );

  always #2 clk = ~clk;

  function automatic string report_text(input frame_report_t r);
    return $sformatf("st=%0d mode=%h btn=%h stk=%h bc=%b sc=%b prs=%h rel=%h an=%h",
                     r.status, r.mode, r.buttons, r.stick, r.buttons_changed,
                     r.stick_changed, r.pressed, r.released, r.analog);
  endfunction

  function automatic gpfp_pkg::byte_t random_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return gpfp_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // frame bookkeeping for one accepted byte; pushes a report when a frame closes
  task automatic predict_byte(input gpfp_pkg::byte_t rx, input logic start);
    frame_report_t rep;
    int unsigned   frame_len;
    if (start) begin
      model_pos  = '0;
      model_open = 1'b1;
    end
    if (model_open) begin
      if (model_pos < gpfp_pkg::STORE_BYTES) model_store[model_pos] = rx;
      model_pos = model_pos + 5'd1;
      frame_len = (model_store[gpfp_pkg::MODE_POS] == gpfp_pkg::MODE_PRESSURE)
                ? gpfp_pkg::LONG_FRAME_BYTES : gpfp_pkg::BASE_FRAME_BYTES;
      if (model_pos >= frame_len) begin
        model_open = 1'b0;
        model_pos  = '0;
        rep.mode   = model_store[gpfp_pkg::MODE_POS];
        if (rep.mode == gpfp_pkg::MODE_DIGITAL || rep.mode == gpfp_pkg::MODE_ANALOG ||
            rep.mode == gpfp_pkg::MODE_PRESSURE) begin
          model_prev_buttons = model_buttons;
          model_buttons      = {model_store[gpfp_pkg::BTN_HI_POS],
                                model_store[gpfp_pkg::BTN_LO_POS]};
          model_prev_stick   = model_stick;
          model_stick        = {model_store[gpfp_pkg::STICK_HI_POS],
                                model_store[gpfp_pkg::STICK_LO_POS]};
          rep.status         = gpfp_pkg::STATUS_OK;
        end else begin
          rep.status = ((rep.mode & gpfp_pkg::MODE_CFG_MASK) == gpfp_pkg::MODE_CFG_MASK)
                     ? gpfp_pkg::STATUS_CFG : gpfp_pkg::STATUS_BAD;
          foreach (model_store[i]) model_store[i] = '0;
        end
        rep.buttons         = model_buttons;
        rep.stick           = model_stick;
        rep.buttons_changed = (model_buttons != model_prev_buttons);
        rep.stick_changed   = (model_stick != model_prev_stick);
        rep.pressed         = rep.buttons_changed ? ~model_buttons : '0;
        rep.released        = rep.buttons_changed ? ~model_prev_buttons : '0;
        // analog byte is read after any clearing
        rep.analog          = (model_analog_index < gpfp_pkg::STORE_BYTES) ?
                              model_store[model_analog_index] : '0;
        expected_reports.push_back(rep);
        status_seen[rep.status]++;
      end
    end
  endtask

  // one request on the input channel; valid is left high for a back-to-back byte
  task automatic send_byte(input gpfp_pkg::byte_t rx, input logic start);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= rx;
    in_frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    predict_byte(rx, start);
  endtask

  task automatic send_frame_buf();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == 0);
  endtask

  task automatic fill_frame(input gpfp_pkg::byte_t mode, input gpfp_pkg::byte_t fill);
    int len;
    len = (mode == gpfp_pkg::MODE_PRESSURE) ? gpfp_pkg::LONG_FRAME_BYTES
                                            : gpfp_pkg::BASE_FRAME_BYTES;
    frame_buf = {};
    repeat (len) frame_buf.push_back(fill);
    frame_buf[gpfp_pkg::MODE_POS] = mode;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_analog_index(input logic [4:0] idx);
    drain_results();
    cfg_valid        <= 1'b1;
    cfg_analog_index <= idx;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid          <= 1'b0;
    model_analog_index = idx;
    index_settings++;
  endtask

  // stray byte with no frame open, then a long-frame header cut short by a restart
  task automatic test_stray_and_restart();
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(gpfp_pkg::MODE_PRESSURE, 1'b0);
    send_byte(8'h5A, 1'b0);
    fill_frame(gpfp_pkg::MODE_DIGITAL, 8'hFF);
    send_frame_buf();
  endtask

  task automatic test_digital_extremes();
    fill_frame(gpfp_pkg::MODE_DIGITAL, 8'h00);
    send_frame_buf();
    // same words again: no change flags, zero masks
    fill_frame(gpfp_pkg::MODE_ANALOG, 8'h00);
    send_frame_buf();
  endtask

  task automatic test_invalid_modes();
    fill_frame(8'hFF, 8'h3C);
    send_frame_buf();
    fill_frame(8'h00, 8'hC3);
    send_frame_buf();
  endtask

  task automatic send_random_frame();
    int              kind;
    int              cut;
    gpfp_pkg::byte_t mode;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1, 2: mode = gpfp_pkg::MODE_DIGITAL;
      3, 4:    mode = gpfp_pkg::MODE_ANALOG;
      5, 6:    mode = gpfp_pkg::MODE_PRESSURE;
      7:       mode = gpfp_pkg::MODE_CFG_MASK | gpfp_pkg::byte_t'($urandom_range(0, 15));
      default: mode = random_byte();
    endcase
    fill_frame(mode, 8'h00);
    foreach (frame_buf[i]) if (i != gpfp_pkg::MODE_POS) frame_buf[i] = random_byte();
    // repeat the latched words now and then so unchanged flags come up
    if ($urandom_range(0, 2) == 0) begin
      frame_buf[gpfp_pkg::BTN_LO_POS] = model_buttons[7:0];
      frame_buf[gpfp_pkg::BTN_HI_POS] = model_buttons[15:8];
    end
    if ($urandom_range(0, 2) == 0) begin
      frame_buf[gpfp_pkg::STICK_HI_POS] = model_stick[15:8];
      frame_buf[gpfp_pkg::STICK_LO_POS] = model_stick[7:0];
    end
    if (kind < 80) begin
      send_frame_buf();
    end else if (kind < 88) begin
      cut = $urandom_range(1, frame_buf.size() - 1);
      for (int i = 0; i < cut; i++) send_byte(frame_buf[i], i == 0);
    end else if (kind < 94) begin
      repeat ($urandom_range(1, 3)) send_byte(random_byte(), 1'b0);
    end else begin
      cut = $urandom_range(1, frame_buf.size() - 1);
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == 0 || i == cut);
    end
  endtask

  task automatic test_random_phases();
    logic [4:0] idx_list [9];
    int         phase_start;
    idx_list = '{5'd20, 5'd21, 5'd31, 5'd0, 5'd5, 5'd15, 5'd9, 5'd3, 5'd0};
    idx_list[8] = 5'($urandom_range(0, 20));
    for (int p = 0; p < 9; p++) begin
      write_analog_index(idx_list[p]);
      // one phase runs flat out on both channels
      idle_on     = (p != 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_frame();
    end
  endtask

  // result side: random stall before each result
  initial begin : result_sink
    int hold;
    forever begin
      hold = idle_on ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    frame_report_t got;
    frame_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_frame_status, out_mode_id, out_button_bits, out_left_stick,
             out_buttons_changed, out_stick_changed, out_pressed_mask,
             out_released_mask, out_analog_value};
      reports_checked++;
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t unexpected result: %s", $realtime, report_text(got));
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("%0t mismatch expected %s", $realtime, report_text(want));
            $display("%0t          actual   %s", $realtime, report_text(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_reports.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    model_analog_index = gpfp_pkg::ANALOG_INDEX_RESET;
    model_pos          = '0;
    model_open         = 1'b0;
    foreach (model_store[i]) model_store[i] = '0;
    model_buttons      = '0;
    model_prev_buttons = '0;
    model_stick        = '0;
    model_prev_stick   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_and_restart();
    test_digital_extremes();
    test_invalid_modes();
    test_random_phases();
    drain_results();
    $display("sent %0d bytes, checked %0d results across %0d analog index settings",
             bytes_sent, reports_checked, index_settings);
    $display("frame outcomes: %0d valid, %0d config mode, %0d bad header",
             status_seen[gpfp_pkg::STATUS_OK], status_seen[gpfp_pkg::STATUS_CFG],
             status_seen[gpfp_pkg::STATUS_BAD]);
    if (failures == 0 && expected_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
